// ===== rtl/assert_macros.svh =====
// assertion macros used by the engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every edge out of reset
`define SDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDD_ASSERT_IMPL(label, ante, cons, msg)
`define SDD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/sdd_pkg.sv =====
// shared types and constants of the sort and dedup engine
package sdd_pkg;

    localparam int SDD_CAPACITY = 64;
    localparam int SDD_DATA_W   = 32;

    typedef struct packed {
        logic                         kind;
        logic signed [SDD_DATA_W-1:0] value;
    } sdd_in_t;

    typedef struct packed {
        logic signed [SDD_DATA_W-1:0] value_res;
        logic                         last;
        logic                         empty_res;
        logic                         overflow;
    } sdd_out_t;

    // control from the sequencer to the minimum unit
    typedef struct packed {
        logic clr;
        logic vld;
        logic have_thr;
    } sdd_ctl_t;

endpackage

// ===== rtl/sort_and_dedup_engine_unit.sv =====
// top level of the sort and dedup engine
//
// input words (s_valid/s_ready/s_data) with kind 0 append a signed value to the
// set, one per cycle, into an on-chip store of CAPACITY entries; values past
// capacity are dropped and the set is flagged overflow
// a word with kind 1 ends the set: s_ready drops while the block works
// each pass reads all n stored values through one compare unit and picks the
// smallest value strictly above the last one kept, if any, so a pass yields the next
// distinct value in ascending order and duplicates never appear
// k distinct values take k + 1 passes; the last pass finds no value above the
// final one kept and so marks that word last
// result words (m_valid/m_ready/m_data) come from an output register; last marks
// the final word of a set, an empty set gives one word with empty_res and last
// a stalled receiver holds the word in the output register and the sequencer
// waits for it before loading the next one
// reset clears the set count, the overflow flag and the output valid; the
// store itself needs no clearing, only entries below the count are read
module sort_and_dedup_engine_unit #(
    parameter int CAPACITY = sdd_pkg::SDD_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sdd_pkg::sdd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sdd_pkg::sdd_out_t m_data
);
    import sdd_pkg::*;
`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_WAIT   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_EMPTY  = 5'b10000
    } sdd_state_t;

    sdd_state_t state_reg, state_next;

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         drop_reg, drop_next;
    logic                         have_thr_reg, have_thr_next;
    logic signed [SDD_DATA_W-1:0] thr_reg, thr_next;
    logic                         cmp_vld_reg;
    logic signed [SDD_DATA_W-1:0] rdata_reg;
    logic                         m_valid_reg, m_valid_next;
    sdd_out_t                     m_data_reg, m_data_next;

    // element store
    logic signed [SDD_DATA_W-1:0] mem [CAPACITY];

    logic                         in_acc;
    logic                         wr_en;
    logic                         out_free;
    logic                         last_issue;
    logic                         restart;
    sdd_ctl_t                     ctl;
    logic signed [SDD_DATA_W-1:0] best;
    logic                         best_ok;

    assign s_ready    = (state_reg == ST_LOAD);
    assign in_acc     = s_valid && s_ready;
    assign wr_en      = in_acc && !s_data.kind && (cnt_reg < CNT_W'(CAPACITY));
    assign out_free   = !m_valid_reg || m_ready;
    assign last_issue = (idx_reg + CNT_W'(1)) == cnt_reg;

    // a new pass starts after every decision that found a value
    assign restart = (state_reg == ST_DECIDE) && best_ok && (!have_thr_reg || out_free);

    assign ctl.clr      = (state_reg == ST_LOAD) || restart;
    assign ctl.vld      = cmp_vld_reg;
    assign ctl.have_thr = have_thr_reg;

    sdd_min_unit u_min (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .data    (rdata_reg),
        .thr     (thr_reg),
        .best    (best),
        .best_ok (best_ok)
    );

    // store write on append, registered read on the scan address
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[AW-1:0]] <= s_data.value;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        drop_next     = drop_reg;
        have_thr_next = have_thr_reg;
        thr_next      = thr_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_LOAD: begin
                idx_next      = '0;
                have_thr_next = 1'b0;
                if (in_acc) begin
                    if (!s_data.kind) begin
                        if (wr_en) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else if (cnt_reg == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + CNT_W'(1);
                if (last_issue) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // last compare lands in the minimum unit this cycle
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!have_thr_reg) begin
                    // first pass always finds the minimum of a non-empty set
                    have_thr_next = 1'b1;
                    thr_next      = best;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end else if (out_free) begin
                    // the value kept last pass is now known to be last or not
                    m_valid_next          = 1'b1;
                    m_data_next.value_res = thr_reg;
                    m_data_next.last      = !best_ok;
                    m_data_next.empty_res = 1'b0;
                    m_data_next.overflow  = drop_reg;
                    if (best_ok) begin
                        thr_next   = best;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.value_res = '0;
                    m_data_next.last      = 1'b1;
                    m_data_next.empty_res = 1'b1;
                    m_data_next.overflow  = drop_reg;
                    drop_next             = 1'b0;
                    state_next            = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            drop_reg     <= 1'b0;
            have_thr_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            drop_reg     <= drop_next;
            have_thr_reg <= have_thr_next;
            cmp_vld_reg  <= (state_reg == ST_SCAN);
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        thr_reg    <= thr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SDD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "set count past capacity")
    `SDD_ASSERT_IMPL(a_empty_last, m_valid_reg && m_data_reg.empty_res, m_data_reg.last, "empty word without last")
    `SDD_ASSERT_IMPL(a_first_pass, (state_reg == ST_DECIDE) && !have_thr_reg, best_ok, "first pass found no minimum")
    `SDD_ASSERT_IMPL(a_ascending, best_ok && have_thr_reg && !ctl.clr, best > thr_reg, "candidate not above kept value")
    `SDD_ASSERT_NEXT(a_idle_scan, state_reg == ST_LOAD, !cmp_vld_reg, "compare active outside a pass")

endmodule

// ===== rtl/sdd_min_unit.sv =====
// shared compare unit: running minimum above a threshold
module sdd_min_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sdd_pkg::sdd_ctl_t                    ctl,
    input  logic signed [sdd_pkg::SDD_DATA_W-1:0] data,
    input  logic signed [sdd_pkg::SDD_DATA_W-1:0] thr,
    output logic signed [sdd_pkg::SDD_DATA_W-1:0] best,
    output logic                                 best_ok
);
    import sdd_pkg::*;

    logic signed [SDD_DATA_W-1:0] best_reg, best_next;
    logic                         best_ok_reg, best_ok_next;
    logic                         above, below, take;

    // candidate must lie strictly above the last kept value, if any, and below the current best
    assign above = !ctl.have_thr || (data > thr);
    assign below = !best_ok_reg || (data < best_reg);
    assign take  = ctl.vld && above && below;

    always_comb begin
        best_next    = best_reg;
        best_ok_next = best_ok_reg;
        priority if (ctl.clr) begin
            best_ok_next = 1'b0;
        end else if (take) begin
            best_next    = data;
            best_ok_next = 1'b1;
        end else begin
            best_next    = best_reg;
            best_ok_next = best_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_ok_reg <= 1'b0;
        end else begin
            best_ok_reg <= best_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    assign best    = best_reg;
    assign best_ok = best_ok_reg;

endmodule

// ===== test/sdd_result_checker.sv =====
// result checker for the sort and dedup engine: tracks sets and predicts the sorted words
module sdd_result_checker #(
    parameter int   CAPACITY = sdd_pkg::SDD_CAPACITY,
    parameter logic KIND_END = 1'b1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sdd_pkg::sdd_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sdd_pkg::sdd_out_t m_data,
    output int                fail_count,
    output int                words_due,
    output int                words_checked
);
    import sdd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the set being collected
    logic signed [SDD_DATA_W-1:0] set_values [CAPACITY];
    int       set_size    = 0;
    bit       set_dropped = 1'b0;

    sdd_out_t sorted_due [$];
    int       mismatch_count = 0;
    int       due_count      = 0;
    int       checked_count  = 0;

    assign fail_count    = mismatch_count;
    assign words_due     = due_count;
    assign words_checked = checked_count;

    function automatic void note_failure(string what, sdd_out_t want, sdd_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected value %0d last %0b empty %0b overflow %0b",
                     $time, what, want.value_res, want.last, want.empty_res, want.overflow);
            $display("    got value %0d last %0b empty %0b overflow %0b",
                     got.value_res, got.last, got.empty_res, got.overflow);
        end
    endfunction

    // sort the set ascending, keep distinct values, queue one word each; an empty set queues one empty word
    function automatic void predict_sorted_set();
        logic signed [SDD_DATA_W-1:0] ordered [CAPACITY];
        logic signed [SDD_DATA_W-1:0] key;
        sdd_out_t word;
        int pos;
        int n_keep;
        for (int i = 0; i < set_size; i++) begin
            key = set_values[i];
            pos = i;
            while (pos > 0 && ordered[pos-1] > key) begin
                ordered[pos] = ordered[pos-1];
                pos--;
            end
            ordered[pos] = key;
        end
        n_keep = 0;
        for (int i = 0; i < set_size; i++) begin
            if (n_keep == 0 || ordered[i] != ordered[n_keep-1]) begin
                ordered[n_keep] = ordered[i];
                n_keep++;
            end
        end
        if (set_size == 0) begin
            word.value_res = '0;
            word.last      = 1'b1;
            word.empty_res = 1'b1;
            word.overflow  = set_dropped;
            sorted_due.insert(sorted_due.size(), word);
        end else begin
            for (int i = 0; i < n_keep; i++) begin
                word.value_res = ordered[i];
                word.last      = (i == n_keep - 1);
                word.empty_res = 1'b0;
                word.overflow  = set_dropped;
                sorted_due.insert(sorted_due.size(), word);
            end
        end
        set_size    = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic void take_word(sdd_in_t word);
        if (word.kind == KIND_END) begin
            predict_sorted_set();
        end else if (set_size < CAPACITY) begin
            set_values[set_size] = word.value;
            set_size++;
        end else begin
            set_dropped = 1'b1;
        end
    endfunction

    function automatic void check_word(sdd_out_t got);
        sdd_out_t want;
        bit       bad;
        if (sorted_due.size() == 0) begin
            want = '0;
            note_failure("result word with nothing expected", want, got);
            return;
        end
        want = sorted_due[0];
        sorted_due.delete(0);
        checked_count++;
        // an empty-set word carries value 0
        bad = (got.last !== want.last) || (got.empty_res !== want.empty_res) ||
              (got.overflow !== want.overflow) || (got.value_res !== want.value_res);
        if (bad) begin
            note_failure("result mismatch", want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            set_size    = 0;
            set_dropped = 1'b0;
            sorted_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_word(m_data);
            end
            if (s_valid && s_ready) begin
                take_word(s_data);
            end
        end
        due_count = sorted_due.size();
    end

endmodule

// ===== test/tb_sort_and_dedup_engine_unit.sv =====
// testbench top for the sort and dedup engine: stimulus, receiver pacing and verdict
module tb_sort_and_dedup_engine_unit;
    import sdd_pkg::*;

    localparam int   CAPACITY     = SDD_CAPACITY;
    localparam int   ITEM_TARGET  = 450;
    // this leaves a wide margin over the slowest run
    localparam int   CYCLE_LIMIT  = 1_000_000;
    localparam int   DRAIN_CYCLES = 300;
    localparam int   HOLD_CYCLES  = 800;
    localparam int   HOLD_EVERY   = 25;
    localparam logic KIND_APPEND  = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam logic signed [SDD_DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [SDD_DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // how the values of one set are drawn
    typedef enum int {
        MIX_DUPS,
        MIX_FULL,
        MIX_EDGES,
        MIX_DESCEND
    } value_mix_e;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    sdd_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    sdd_out_t  m_data;

    int fail_count;
    int words_due;
    int words_checked;

    // stimulus bookkeeping, read by the receiver and the summary
    int words_sent      = 0;
    int sets_ended      = 0;
    int sets_overflowed = 0;
    int largest_set     = 0;
    int burst_left      = 0;
    int cycle_count     = 0;

    sort_and_dedup_engine_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sdd_result_checker #(
        .CAPACITY (CAPACITY),
        .KIND_END (KIND_END)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // receiver pacing: a random stall level of 0, 20, 60 or 90 percent, level 0 gives
    // clean stretches; every HOLD_EVERY sets it also holds off for a long
    // stretch so the output backs up and s_ready stays low while words wait
    initial begin : receiver
        int hold_left;
        int stall_pct;
        int hold_at;
        int tick;
        hold_left = 0;
        stall_pct = 0;
        hold_at   = 3;
        tick      = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (tick % 128 == 0) begin
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_left == 0 && sets_ended >= hold_at) begin
                hold_left = HOLD_CYCLES;
                hold_at   = hold_at + HOLD_EVERY;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one word and wait for its handshake; the sender runs in bursts
    // with random gaps between them, gap 0 keeps valid high across the edge
    task automatic send_word(input logic kind, input logic signed [SDD_DATA_W-1:0] value);
        sdd_in_t word;
        int      gap;
        word.kind  = kind;
        word.value = value;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    // end word; its value field is ignored, so it carries noise
    task automatic end_set(input int n_elem);
        send_word(KIND_END, $urandom);
        sets_ended++;
        if (n_elem > CAPACITY) sets_overflowed++;
        if (n_elem > largest_set) largest_set = n_elem;
    endtask

    function automatic logic signed [SDD_DATA_W-1:0] pick_value(
        input value_mix_e mix, input int idx, input logic signed [SDD_DATA_W-1:0] base);
        logic signed [SDD_DATA_W-1:0] v;
        case (mix)
            MIX_DUPS:  v = int'($urandom_range(8)) - 4;
            MIX_FULL:  v = $urandom;
            MIX_EDGES: begin
                case ($urandom_range(6))
                    0:       v = VALUE_MIN;
                    1:       v = VALUE_MIN + 1;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = VALUE_MAX - 1;
                    default: v = VALUE_MAX;
                endcase
            end
            default:   v = base - idx;
        endcase
        return v;
    endfunction

    task automatic send_set(input int n_elem, input value_mix_e mix);
        logic signed [SDD_DATA_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < n_elem; i++) begin
            send_word(KIND_APPEND, pick_value(mix, i, base));
        end
        end_set(n_elem);
    endtask

    initial begin : stimulus
        int         r;
        int         n_elem;
        value_mix_e mix;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty set right after reset
        end_set(0);
        // extremes of the value range, out of order and repeated
        send_word(KIND_APPEND, VALUE_MAX);
        send_word(KIND_APPEND, VALUE_MIN);
        send_word(KIND_APPEND, 0);
        send_word(KIND_APPEND, -1);
        send_word(KIND_APPEND, 1);
        send_word(KIND_APPEND, VALUE_MIN);
        send_word(KIND_APPEND, VALUE_MAX);
        end_set(7);
        // every value the same: a single distinct word
        send_word(KIND_APPEND, 7);
        send_word(KIND_APPEND, 7);
        send_word(KIND_APPEND, 7);
        end_set(3);
        // one element
        send_word(KIND_APPEND, -5);
        end_set(1);
        // strictly descending input
        for (int i = 4; i >= 0; i--) send_word(KIND_APPEND, i);
        end_set(5);
        // another empty set, after a non-empty one
        end_set(0);

        // a full store without overflow, then one element past capacity
        send_set(CAPACITY, MIX_FULL);
        send_set(CAPACITY + 1, MIX_EDGES);

        // random sets: mostly small, a few around capacity
        while (words_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 8) n_elem = 0;
            else if (r < 94) n_elem = $urandom_range(12, 1);
            else n_elem = $urandom_range(CAPACITY + 6, CAPACITY - 2);
            mix = value_mix_e'($urandom_range(3));
            send_set(n_elem, mix);
        end

        s_valid <= 1'b0;
        // sample away from the clock edge so the checker has settled
        do @(negedge aclk); while (words_due != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d sets from %0d input words, %0d result words checked",
                 sets_ended, words_sent, words_checked);
        $display("%0d sets overflowed, largest set %0d, %0d mismatches, %0d words still owed",
                 sets_overflowed, largest_set, fail_count, words_due);
        if (fail_count == 0 && words_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
